// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths and constants of the sliding window mean unit.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW = 1024;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int SAMPLE_W   = 32;
	localparam int TAG_W      = 64;
	localparam int SUM_W      = SAMPLE_W + ADDR_W;
	localparam int DATA_W     = TAG_W + SAMPLE_W;
	localparam int STEP_W     = $clog2(SUM_W);

	localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(10);
	localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(MAX_WINDOW);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

endpackage

// ===== rtl/swm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/sliding_window_mean_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean_unit
// Moving average of signed Q16.16 samples over the last window_size samples.
// ----------------------------------------------------------------------------
// Each input transaction carries a 64-bit tag and a signed Q16.16 sample and
// produces exactly one output transaction with the same tag and the mean of
// the samples now in the window (sum / count, truncated toward zero). Until
// window_size samples have arrived since the last clear, the mean is over the
// samples seen so far. A window_size of 0 acts as 1, values above 1024 act
// as 1024; any write to window_size clears the window. Configuration is only
// accepted while no item is in flight, and a pending configuration write
// holds s_tready low so that it wins over a waiting input. Each item passes
// through these steps before the next one is accepted: the acceptance,
// which issues the sample store read; the running-sum update; taking the
// magnitude; a one-bit-per-cycle restoring divider; and, once the output
// register is free, signing the quotient into it. The output register lets
// the next item be accepted while a finished result still waits on m_tready.
// Samples live in a 1024 x 32 synchronous RAM; no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module sliding_window_mean_unit
	import swm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// slave stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [63:0] tag, [95:64] sample
	// master stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [63:0] tag_out, [95:64] mean
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data   // window_size
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	// window state
	logic [CNT_W-1:0]        win_q;
	logic [CNT_W-1:0]        fill_q;
	logic [ADDR_W-1:0]       wp_q;
	logic signed [SUM_W-1:0] sum_q;

	// per-item payload
	logic [TAG_W-1:0]        tag_q;
	logic [SAMPLE_W-1:0]     samp_q;
	logic [ADDR_W-1:0]       pos_q;
	logic                    sub_q;

	// divider
	logic [SUM_W-1:0]        mag_q;
	logic [CNT_W-1:0]        rem_q;
	logic [STEP_W-1:0]       cnt_q;
	logic                    neg_q;

	// output register
	logic                    m_valid_q;
	logic [DATA_W-1:0]       m_data_q;

	logic                    in_acc;
	logic                    cfg_acc;
	logic                    out_free;
	logic [CNT_W-1:0]        eff_win;
	logic [ADDR_W-1:0]       pos_c;
	logic [CNT_W-1:0]        pos_inc;
	logic [SAMPLE_W-1:0]     old_samp;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] sum_next;
	logic [CNT_W:0]          trial;
	logic                    ge;
	logic [CNT_W:0]          trial_sub;
	logic [SAMPLE_W-1:0]     quo;
	logic [SAMPLE_W-1:0]     mean_c;

	// a pending window write goes first
	assign s_tready  = (state_q == ST_IDLE) & ~cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign out_free  = ~m_valid_q | m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	// zero acts as one, oversize saturates
	always_comb begin
		if (win_q == '0) begin
			eff_win = CNT_W'(1);
		end else if (win_q > WIN_MAX) begin
			eff_win = WIN_MAX;
		end else begin
			eff_win = win_q;
		end
	end

	assign pos_c   = ({1'b0, wp_q} >= eff_win) ? '0 : wp_q;
	assign pos_inc = {1'b0, pos_c} + CNT_W'(1);

	// sum update: the oldest sample leaves once the window is full
	assign old_ext  = sub_q ? {{(SUM_W-SAMPLE_W){old_samp[SAMPLE_W-1]}}, old_samp} : '0;
	assign new_ext  = {{(SUM_W-SAMPLE_W){samp_q[SAMPLE_W-1]}}, samp_q};
	assign sum_next = sum_q - old_ext + new_ext;

	// restoring divide step on the magnitude
	assign trial     = {rem_q, mag_q[SUM_W-1]};
	assign ge        = (trial >= {1'b0, fill_q});
	assign trial_sub = trial - {1'b0, fill_q};

	assign quo    = mag_q[SAMPLE_W-1:0];
	assign mean_c = neg_q ? (~quo + SAMPLE_W'(1)) : quo;

	swm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (state_q == ST_READ),
		.waddr (pos_q),
		.wdata (samp_q),
		.re    (in_acc),
		.raddr (pos_c),
		.rdata (old_samp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			win_q     <= WIN_RESET;
			fill_q    <= '0;
			wp_q      <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						win_q  <= cfg_data;
						fill_q <= '0;
						wp_q   <= '0;
						sum_q  <= '0;
					end else if (in_acc) begin
						if (fill_q < eff_win) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						wp_q    <= (pos_inc >= eff_win) ? '0 : pos_inc[ADDR_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q   <= sum_next;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_q  <= s_tdata[TAG_W-1:0];
			samp_q <= s_tdata[DATA_W-1:TAG_W];
			pos_q  <= pos_c;
			sub_q  <= ~(fill_q < eff_win);
		end
		if (state_q == ST_PREP) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			mag_q <= {mag_q[SUM_W-2:0], ge};
			rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= {mean_c, tag_q};
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WIN_MAX)
		else $error("fill count above window maximum");

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !cfg_acc |=> state_q == ST_READ)
		else $error("accepted item did not start a store read");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == LAST_STEP |=> state_q == ST_FIN)
		else $error("divider did not finish after last step");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> fill_q == '0 && wp_q == '0 && sum_q == '0)
		else $error("window not cleared by configuration write");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> fill_q != '0)
		else $error("divide by zero count");

endmodule
